FILE: src/pokf_pkg.sv
`timescale 1ns / 1ps
package pokf_pkg;

  localparam int DATA_W     = 48;
  localparam int FRAC_W     = 32;
  localparam int TS_W       = 33;
  localparam int NOISE_W    = 47;
  localparam int HALF_W     = DATA_W / 2;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int QUO_W      = DATA_W + FRAC_W;
  localparam int DIV_CNT_W  = 7;
  localparam int ADDR_W     = 7;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int CODE_W     = 8;
  localparam int PC_W       = 9;
  localparam int PROG_DEPTH = 1 << PC_W;

  localparam logic signed [DATA_W-1:0] VMAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(64'd1 << FRAC_W);

  localparam logic [TS_W-1:0]    TS_RESET    = TS_W'(429496730);
  localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(4294967);

  typedef enum logic [1:0] {
    CMD_VEL  = 2'd0,
    CMD_YAW  = 2'd1,
    CMD_PRED = 2'd2,
    CMD_MEAS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TIME_STEP  = 2'd0,
    REG_PROC_NOISE = 2'd1,
    REG_MEAS_NOISE = 2'd2,
    REG_INIT_COV   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CHKZ = 3'd4,
    OP_ENDN = 3'd5,
    OP_ENDR = 3'd6
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dst;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
  } instr_t;

  typedef instr_t [PROG_DEPTH-1:0] prog_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // operand sources outside the scratch memory
  localparam int K_ZERO = 128;
  localparam int K_ONE  = 129;
  localparam int K_DT   = 130;
  localparam int K_Q    = 131;
  localparam int K_RN   = 132;
  localparam int K_IC   = 133;
  localparam int K_VX   = 134;
  localparam int K_VY   = 135;
  localparam int K_YR   = 136;
  localparam int K_ZX   = 137;
  localparam int K_ZY   = 138;
  localparam int K_ZH   = 139;

  // scratch memory map
  localparam int A_P   = 0;
  localparam int A_C   = 3;
  localparam int A_V   = 12;
  localparam int A_DX  = 16;
  localparam int A_DY  = 17;
  localparam int A_DH  = 18;
  localparam int A_Q   = 19;
  localparam int A_F2  = 22;
  localparam int A_F5  = 23;
  localparam int A_X   = 24;
  localparam int A_U   = 25;
  localparam int A_DET = 26;
  localparam int A_Y   = 27;
  localparam int A_S   = 30;
  localparam int A_T   = 33;
  localparam int A_CF  = 42;
  localparam int A_I   = 51;
  localparam int A_G   = 60;

  localparam int M_F  = 0;
  localparam int M_FT = 1;
  localparam int M_C  = 2;
  localparam int M_T  = 3;
  localparam int M_I  = 4;
  localparam int M_G  = 5;
  localparam int M_S  = 6;

  localparam logic [PC_W-1:0] PC_INIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_RELOAD = PC_W'(6);
  localparam logic [PC_W-1:0] PC_VEL    = PC_W'(16);
  localparam logic [PC_W-1:0] PC_YAW    = PC_W'(19);
  localparam logic [PC_W-1:0] PC_PRED   = PC_W'(21);
  localparam logic [PC_W-1:0] PC_MEAS   = PC_W'(128);

  function automatic logic signed [DATA_W-1:0] sat_mag(logic [QUO_W-1:0] m, logic n);
    logic signed [DATA_W-1:0] v;
    v = $signed(m[DATA_W-1:0]);
    if (|m[QUO_W-1:DATA_W-1]) return n ? VMIN : VMAX;
    return n ? -v : v;
  endfunction

  function automatic instr_t mk(op_t op, int d, int a, int b);
    instr_t r;
    r.op  = op;
    r.dst = ADDR_W'(d);
    r.a   = CODE_W'(a);
    r.b   = CODE_W'(b);
    return r;
  endfunction

  function automatic int mcode(int sel, int idx);
    int c;
    c = K_ZERO;
    case (sel)
      M_F: begin
        if (idx == 0 || idx == 4 || idx == 8) c = K_ONE;
        else if (idx == 2) c = A_F2;
        else if (idx == 5) c = A_F5;
      end
      M_FT: begin
        if (idx == 0 || idx == 4 || idx == 8) c = K_ONE;
        else if (idx == 6) c = A_F2;
        else if (idx == 7) c = A_F5;
      end
      M_C: c = A_C + idx;
      M_T: c = A_T + idx;
      M_I: c = A_I + idx;
      M_G: c = A_G + idx;
      M_S: begin
        if (idx == 0) c = A_S;
        else if (idx == 4) c = A_S + 1;
        else if (idx == 8) c = A_S + 2;
        else c = A_C + idx;
      end
      default: c = K_ZERO;
    endcase
    return c;
  endfunction

  function automatic instr_t mm_instr(int as, int bs, int rs, int k);
    int e;
    int s;
    int i;
    int j;
    instr_t r;
    e = k / 5;
    s = k % 5;
    i = e / 3;
    j = e % 3;
    case (s)
      0:       r = mk(OP_MUL, A_X, mcode(as, i * 3), mcode(bs, j));
      1:       r = mk(OP_MUL, A_U, mcode(as, i * 3 + 1), mcode(bs, 3 + j));
      2:       r = mk(OP_ADD, A_X, A_X, A_U);
      3:       r = mk(OP_MUL, A_U, mcode(as, i * 3 + 2), mcode(bs, 6 + j));
      default: r = mk(OP_ADD, mcode(rs, e), A_X, A_U);
    endcase
    return r;
  endfunction

  function automatic prog_t build_prog();
    prog_t p;
    int n;
    int i1;
    int i2;
    int j1;
    int j2;
    for (int k = 0; k < PROG_DEPTH; k++) p[k] = mk(OP_ENDN, 0, K_ZERO, K_ZERO);
    n = 0;
    // reset: pose and control to zero, then covariance load
    for (int k = 0; k < 3; k++) begin p[n] = mk(OP_ADD, A_P + k, K_ZERO, K_ZERO); n = n + 1; end
    for (int k = 0; k < 3; k++) begin p[n] = mk(OP_ADD, A_V + k, K_ZERO, K_ZERO); n = n + 1; end
    for (int k = 0; k < 9; k++) begin
      p[n] = mk(OP_ADD, A_C + k, (k % 4 == 0) ? K_IC : K_ZERO, K_ZERO);
      n = n + 1;
    end
    p[n] = mk(OP_ENDN, 0, K_ZERO, K_ZERO); n = n + 1;
    // velocity
    p[n] = mk(OP_ADD, A_V, K_VX, K_ZERO); n = n + 1;
    p[n] = mk(OP_ADD, A_V + 1, K_VY, K_ZERO); n = n + 1;
    p[n] = mk(OP_ENDN, 0, K_ZERO, K_ZERO); n = n + 1;
    // yaw rate
    p[n] = mk(OP_ADD, A_V + 2, K_YR, K_ZERO); n = n + 1;
    p[n] = mk(OP_ENDN, 0, K_ZERO, K_ZERO); n = n + 1;
    // predict
    p[n] = mk(OP_MUL, A_DX, A_V, K_DT); n = n + 1;
    p[n] = mk(OP_MUL, A_DY, A_V + 1, K_DT); n = n + 1;
    p[n] = mk(OP_MUL, A_DH, A_V + 2, K_DT); n = n + 1;
    p[n] = mk(OP_ADD, A_Q, A_P, A_DX); n = n + 1;
    p[n] = mk(OP_ADD, A_Q + 1, A_P + 1, A_DY); n = n + 1;
    p[n] = mk(OP_ADD, A_Q + 2, A_P + 2, A_DH); n = n + 1;
    p[n] = mk(OP_SUB, A_F2, K_ZERO, A_DY); n = n + 1;
    p[n] = mk(OP_ADD, A_F5, A_DX, K_ZERO); n = n + 1;
    p[n] = mk(OP_MUL, A_U, A_F2, A_Q + 2); n = n + 1;
    p[n] = mk(OP_ADD, A_P, A_Q, A_U); n = n + 1;
    p[n] = mk(OP_MUL, A_U, A_F5, A_Q + 2); n = n + 1;
    p[n] = mk(OP_ADD, A_P + 1, A_Q + 1, A_U); n = n + 1;
    p[n] = mk(OP_ADD, A_P + 2, A_Q + 2, K_ZERO); n = n + 1;
    for (int k = 0; k < 45; k++) begin p[n] = mm_instr(M_F, M_C, M_T, k); n = n + 1; end
    for (int k = 0; k < 45; k++) begin p[n] = mm_instr(M_T, M_FT, M_C, k); n = n + 1; end
    for (int k = 0; k < 3; k++) begin p[n] = mk(OP_ADD, A_C + 4 * k, A_C + 4 * k, K_Q); n = n + 1; end
    p[n] = mk(OP_ENDN, 0, K_ZERO, K_ZERO); n = n + 1;
    // measurement
    for (int k = 0; k < 3; k++) begin p[n] = mk(OP_ADD, A_S + k, A_C + 4 * k, K_RN); n = n + 1; end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        p[n] = mk(OP_MUL, A_X, mcode(M_S, i1 * 3 + j1), mcode(M_S, i2 * 3 + j2)); n = n + 1;
        p[n] = mk(OP_MUL, A_U, mcode(M_S, i1 * 3 + j2), mcode(M_S, i2 * 3 + j1)); n = n + 1;
        p[n] = mk(OP_SUB, A_CF + i * 3 + j, A_X, A_U); n = n + 1;
      end
    end
    p[n] = mk(OP_MUL, A_X, mcode(M_S, 0), A_CF); n = n + 1;
    p[n] = mk(OP_MUL, A_U, mcode(M_S, 1), A_CF + 1); n = n + 1;
    p[n] = mk(OP_ADD, A_X, A_X, A_U); n = n + 1;
    p[n] = mk(OP_MUL, A_U, mcode(M_S, 2), A_CF + 2); n = n + 1;
    p[n] = mk(OP_ADD, A_DET, A_X, A_U); n = n + 1;
    p[n] = mk(OP_CHKZ, 0, A_DET, K_ZERO); n = n + 1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[n] = mk(OP_DIV, A_I + i * 3 + j, A_CF + j * 3 + i, A_DET); n = n + 1;
      end
    end
    for (int k = 0; k < 45; k++) begin p[n] = mm_instr(M_C, M_I, M_G, k); n = n + 1; end
    for (int k = 0; k < 3; k++) begin p[n] = mk(OP_SUB, A_Y + k, K_ZX + k, A_P + k); n = n + 1; end
    for (int i = 0; i < 3; i++) begin
      p[n] = mk(OP_MUL, A_U, A_G + i * 3, A_Y); n = n + 1;
      p[n] = mk(OP_ADD, A_X, A_P + i, A_U); n = n + 1;
      p[n] = mk(OP_MUL, A_U, A_G + i * 3 + 1, A_Y + 1); n = n + 1;
      p[n] = mk(OP_ADD, A_X, A_X, A_U); n = n + 1;
      p[n] = mk(OP_MUL, A_U, A_G + i * 3 + 2, A_Y + 2); n = n + 1;
      p[n] = mk(OP_ADD, A_P + i, A_X, A_U); n = n + 1;
    end
    for (int k = 0; k < 9; k++) begin
      p[n] = mk(OP_SUB, A_G + k, (k % 4 == 0) ? K_ONE : K_ZERO, A_G + k);
      n = n + 1;
    end
    for (int k = 0; k < 45; k++) begin p[n] = mm_instr(M_G, M_C, M_T, k); n = n + 1; end
    for (int k = 0; k < 9; k++) begin p[n] = mk(OP_ADD, A_C + k, A_T + k, K_ZERO); n = n + 1; end
    p[n] = mk(OP_ENDR, 0, K_ZERO, K_ZERO);
    return p;
  endfunction

endpackage

FILE: src/pokf_alu.sv
`timescale 1ns / 1ps
module pokf_alu (
  input  logic                                clk,
  input  logic                                rst,
  input  pokf_pkg::alu_req_t                  req,
  input  logic signed [pokf_pkg::DATA_W-1:0]  a,
  input  logic signed [pokf_pkg::DATA_W-1:0]  b,
  output logic                                done,
  output logic signed [pokf_pkg::DATA_W-1:0]  res
);
  import pokf_pkg::*;

  typedef enum logic [4:0] {
    AS_IDLE = 5'b00001,
    AS_MUL  = 5'b00010,
    AS_MRND = 5'b00100,
    AS_DIV  = 5'b01000,
    AS_DFIN = 5'b10000
  } alu_state_t;

  alu_state_t state;
  logic [DATA_W-1:0] mag_a, mag_b, ma, mb;
  logic neg;
  logic [1:0] pcnt;
  logic [HALF_W-1:0] pa, pb;
  logic [DATA_W-1:0] part;
  logic [PROD_W-1:0] acc, part_sh, acc_rnd;
  logic [PROD_W-FRAC_W-1:0] rnd_mag;
  logic [DATA_W:0] sum, dif;
  logic signed [DATA_W-1:0] sum_sat, dif_sat;
  logic [QUO_W-1:0] dvd, quo;
  logic [DATA_W-1:0] rem, rem_next;
  logic [DATA_W:0] rem_sh, rem_sub;
  logic rem_ge;
  logic [DIV_CNT_W-1:0] dcnt;

  assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

  assign sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign dif = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  assign sum_sat = (sum[DATA_W] != sum[DATA_W-1]) ? (sum[DATA_W] ? VMIN : VMAX)
                                                  : $signed(sum[DATA_W-1:0]);
  assign dif_sat = (dif[DATA_W] != dif[DATA_W-1]) ? (dif[DATA_W] ? VMIN : VMAX)
                                                  : $signed(dif[DATA_W-1:0]);

  assign pa   = pcnt[1] ? ma[DATA_W-1:HALF_W] : ma[HALF_W-1:0];
  assign pb   = pcnt[0] ? mb[DATA_W-1:HALF_W] : mb[HALF_W-1:0];
  assign part = DATA_W'(pa) * DATA_W'(pb);

  always_comb begin
    case (pcnt)
      2'd0:       part_sh = PROD_W'(part);
      2'd1, 2'd2: part_sh = PROD_W'(part) << HALF_W;
      default:    part_sh = PROD_W'(part) << DATA_W;
    endcase
  end

  assign acc_rnd = acc + (PROD_W'(1) << (FRAC_W - 1));
  assign rnd_mag = acc_rnd[PROD_W-1:FRAC_W];

  assign rem_sh   = {rem, dvd[QUO_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, mb};
  assign rem_sub  = rem_sh - {1'b0, mb};
  assign rem_next = rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= ((state == AS_IDLE) && req.start && !(req.op inside {OP_MUL, OP_DIV}))
              || (state == AS_MRND) || (state == AS_DFIN);
      case (state)
        AS_IDLE: begin
          if (req.start) begin
            case (req.op)
              OP_ADD: res <= sum_sat;
              OP_SUB: res <= dif_sat;
              OP_MUL: begin
                ma    <= mag_a;
                mb    <= mag_b;
                neg   <= a[DATA_W-1] ^ b[DATA_W-1];
                acc   <= '0;
                pcnt  <= '0;
                state <= AS_MUL;
              end
              OP_DIV: begin
                mb    <= mag_b;
                dvd   <= {mag_a, FRAC_W'(0)};
                quo   <= '0;
                rem   <= '0;
                dcnt  <= '0;
                neg   <= a[DATA_W-1] ^ b[DATA_W-1];
                state <= AS_DIV;
              end
              default: ;
            endcase
          end
        end
        AS_MUL: begin
          acc  <= acc + part_sh;
          pcnt <= pcnt + 2'd1;
          if (pcnt == 2'd3) state <= AS_MRND;
        end
        AS_MRND: begin
          res   <= sat_mag(QUO_W'(rnd_mag), neg);
          state <= AS_IDLE;
        end
        AS_DIV: begin
          rem  <= rem_next;
          quo  <= {quo[QUO_W-2:0], rem_ge};
          dvd  <= dvd << 1;
          dcnt <= dcnt + DIV_CNT_W'(1);
          if (dcnt == DIV_CNT_W'(QUO_W - 1)) state <= AS_DFIN;
        end
        AS_DFIN: begin
          res   <= sat_mag(quo, neg);
          state <= AS_IDLE;
        end
        default: state <= AS_IDLE;
      endcase
    end
  end

endmodule

FILE: src/planar_odometry_kalman_filter.sv
`timescale 1ns / 1ps
// A measurement ends early, skipping the update, when the innovation matrix is singular.
// One command at a time; each add, subtract, multiply and divide microinstruction
// runs on the shared saturating unit.
// Reset: synchronous; an initialisation run clears the pose and control and loads
// the covariance; an initial_covariance write reloads it.
module planar_odometry_kalman_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          command,
  input  logic signed [pokf_pkg::DATA_W-1:0]  vel_x,
  input  logic signed [pokf_pkg::DATA_W-1:0]  vel_y,
  input  logic signed [pokf_pkg::DATA_W-1:0]  yaw_rate,
  input  logic signed [pokf_pkg::DATA_W-1:0]  meas_x,
  input  logic signed [pokf_pkg::DATA_W-1:0]  meas_y,
  input  logic signed [pokf_pkg::DATA_W-1:0]  meas_heading,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [pokf_pkg::DATA_W-1:0]  est_x,
  output logic signed [pokf_pkg::DATA_W-1:0]  est_y,
  output logic signed [pokf_pkg::DATA_W-1:0]  est_heading,
  output logic                                singular,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [pokf_pkg::NOISE_W-1:0]        cfg_data
);
  import pokf_pkg::*;

  localparam prog_t PROG = build_prog();

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_WAIT  = 6'b010000,
    S_EMIT  = 6'b100000
  } seq_state_t;

  seq_state_t state;
  logic [PC_W-1:0] pc;
  instr_t ir;
  logic [TS_W-1:0] time_step;
  logic [NOISE_W-1:0] process_noise, measurement_noise, initial_covariance;
  logic signed [DATA_W-1:0] in_vx, in_vy, in_yr, in_zx, in_zy, in_zh;
  logic signed [DATA_W-1:0] mem [MEM_DEPTH];
  logic signed [DATA_W-1:0] rda, rdb, opa, opb;
  logic signed [DATA_W-1:0] pose [3];
  logic sing;
  alu_req_t alu_req;
  logic alu_done;
  logic signed [DATA_W-1:0] alu_res;
  logic mem_wr, cmd_take, cfg_take;

  function automatic logic signed [DATA_W-1:0] pick(logic [CODE_W-1:0] code,
                                                    logic signed [DATA_W-1:0] rd);
    logic signed [DATA_W-1:0] v;
    v = '0;
    if (!code[CODE_W-1]) return rd;
    case (code)
      CODE_W'(K_ONE): v = FIX_ONE;
      CODE_W'(K_DT):  v = $signed(DATA_W'(time_step));
      CODE_W'(K_Q):   v = $signed(DATA_W'(process_noise));
      CODE_W'(K_RN):  v = $signed(DATA_W'(measurement_noise));
      CODE_W'(K_IC):  v = $signed(DATA_W'(initial_covariance));
      CODE_W'(K_VX):  v = in_vx;
      CODE_W'(K_VY):  v = in_vy;
      CODE_W'(K_YR):  v = in_yr;
      CODE_W'(K_ZX):  v = in_zx;
      CODE_W'(K_ZY):  v = in_zy;
      CODE_W'(K_ZH):  v = in_zh;
      default:        v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(ir.a, rda);
  assign opb = pick(ir.b, rdb);

  assign cfg_ready = (state == S_IDLE);
  assign cmd_stall = (state != S_IDLE) || cfg_valid;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign mem_wr    = (state == S_WAIT) && alu_done;

  assign alu_req.start = (state == S_EXEC) && (ir.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});
  assign alu_req.op    = ir.op;

  pokf_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (opa),
    .b    (opb),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (mem_wr) mem[ir.dst] <= alu_res;
    rda <= mem[ir.a[ADDR_W-1:0]];
    rdb <= mem[ir.b[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_FETCH;
      pc                 <= PC_INIT;
      res_valid          <= 1'b0;
      sing               <= 1'b0;
      time_step          <= TS_RESET;
      process_noise      <= NOISE_RESET;
      measurement_noise  <= NOISE_RESET;
      initial_covariance <= NOISE_RESET;
      pose[0]            <= '0;
      pose[1]            <= '0;
      pose[2]            <= '0;
    end else begin
      if (res_valid && !res_stall && state != S_EMIT) res_valid <= 1'b0;
      if (cfg_take) begin
        case (reg_idx_t'(cfg_index))
          REG_TIME_STEP:  time_step <= cfg_data[TS_W-1:0];
          REG_PROC_NOISE: process_noise <= cfg_data;
          REG_MEAS_NOISE: measurement_noise <= cfg_data;
          REG_INIT_COV: begin
            initial_covariance <= cfg_data;
            pc                 <= PC_RELOAD;
            state              <= S_FETCH;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            in_vx <= vel_x;
            in_vy <= vel_y;
            in_yr <= yaw_rate;
            in_zx <= meas_x;
            in_zy <= meas_y;
            in_zh <= meas_heading;
            sing  <= 1'b0;
            state <= S_FETCH;
            case (cmd_t'(command))
              CMD_VEL:  pc <= PC_VEL;
              CMD_YAW:  pc <= PC_YAW;
              CMD_PRED: pc <= PC_PRED;
              default:  pc <= PC_MEAS;
            endcase
          end
        end
        S_FETCH: begin
          ir    <= PROG[pc];
          state <= S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          case (ir.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state <= S_WAIT;
            OP_CHKZ: begin
              if (opa == '0) begin
                sing  <= 1'b1;
                state <= S_EMIT;
              end else begin
                pc    <= pc + PC_W'(1);
                state <= S_FETCH;
              end
            end
            OP_ENDR: state <= S_EMIT;
            default: state <= S_IDLE;
          endcase
        end
        S_WAIT: begin
          if (alu_done) begin
            pc    <= pc + PC_W'(1);
            state <= S_FETCH;
            if (ir.dst <= ADDR_W'(A_P + 2)) pose[ir.dst[1:0]] <= alu_res;
          end
        end
        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            est_x       <= pose[0];
            est_y       <= pose[1];
            est_heading <= pose[2];
            singular    <= sing;
            res_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/tb_planar_odometry_kalman_filter.sv
`timescale 1ns / 1ps
module tb_planar_odometry_kalman_filter;
  import pokf_pkg::*;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef longint mat3_t [9];

  typedef struct {
    cmd_t command;
    fix_t vx;
    fix_t vy;
    fix_t yr;
    fix_t mx;
    fix_t my;
    fix_t mh;
  } odo_cmd_t;

  typedef struct {
    fix_t x;
    fix_t y;
    fix_t h;
    logic sing;
  } pose_est_t;

  localparam longint SAT_HI = VMAX;
  localparam longint SAT_LO = VMIN;
  localparam longint FX_ONE = FIX_ONE;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int SETTLE = 1200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [1:0] command = CMD_VEL;
  fix_t vel_x = '0;
  fix_t vel_y = '0;
  fix_t yaw_rate = '0;
  fix_t meas_x = '0;
  fix_t meas_y = '0;
  fix_t meas_heading = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  fix_t est_x;
  fix_t est_y;
  fix_t est_heading;
  logic singular;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_TIME_STEP;
  logic [NOISE_W-1:0] cfg_data = '0;

  planar_odometry_kalman_filter DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command),
    .vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate),
    .meas_x(meas_x), .meas_y(meas_y), .meas_heading(meas_heading),
    .res_valid(res_valid), .res_stall(res_stall),
    .est_x(est_x), .est_y(est_y), .est_heading(est_heading), .singular(singular),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  odo_cmd_t cmd_pending[$];
  pose_est_t pose_expected[$];
  int errors = 0;
  longint cycles = 0;

  longint pose_s[3];
  longint cov_s[9];
  longint ctrl_s[3];
  logic [63:0] step_r, qnoise_r, rnoise_r, cov0_r;

  function automatic longint clampv(logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return longint'(v);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    logic signed [127:0] t;
    t = a;
    t = t + b;
    return clampv(t);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    logic signed [127:0] t;
    t = a;
    t = t - b;
    return clampv(t);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] x;
    logic [127:0] y;
    logic [127:0] p;
    logic signed [127:0] s;
    x = 128'(a < 0 ? -a : a);
    y = 128'(b < 0 ? -b : b);
    p = (x * y + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
    s = p;
    if ((a < 0) != (b < 0)) s = -s;
    return clampv(s);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    logic [127:0] x;
    logic [127:0] y;
    logic signed [127:0] s;
    if (d == 0) return 0;
    x = 128'(n < 0 ? -n : n);
    y = 128'(d < 0 ? -d : d);
    s = (x << FRAC_W) / y;
    if ((n < 0) != (d < 0)) s = -s;
    return clampv(s);
  endfunction

  function automatic mat3_t mat_mul(mat3_t a, mat3_t b);
    mat3_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i*3+j] = fx_add(fx_add(fx_mul(a[i*3], b[j]), fx_mul(a[i*3+1], b[3+j])),
                          fx_mul(a[i*3+2], b[6+j]));
    return r;
  endfunction

  function automatic longint reg_sat(logic [63:0] r);
    return (r > 64'(SAT_HI)) ? SAT_HI : longint'(r);
  endfunction

  function automatic void reload_cov();
    for (int k = 0; k < 9; k++) cov_s[k] = (k % 4 == 0) ? reg_sat(cov0_r) : 0;
  endfunction

  function automatic void predict_pose();
    longint dt, q, dx, dy, dh, p0, p1, p2;
    mat3_t f, ft, c;
    dt = reg_sat(step_r);
    q = reg_sat(qnoise_r);
    dx = fx_mul(ctrl_s[0], dt);
    dy = fx_mul(ctrl_s[1], dt);
    dh = fx_mul(ctrl_s[2], dt);
    p0 = fx_add(pose_s[0], dx);
    p1 = fx_add(pose_s[1], dy);
    p2 = fx_add(pose_s[2], dh);
    for (int k = 0; k < 9; k++) begin
      f[k] = (k % 4 == 0) ? FX_ONE : 0;
      ft[k] = f[k];
    end
    f[2] = fx_sub(0, dy);
    f[5] = dx;
    ft[6] = f[2];
    ft[7] = f[5];
    pose_s[0] = fx_add(p0, fx_mul(f[2], p2));
    pose_s[1] = fx_add(p1, fx_mul(f[5], p2));
    pose_s[2] = p2;
    c = cov_s;
    c = mat_mul(f, c);
    c = mat_mul(c, ft);
    for (int k = 0; k < 9; k += 4) c[k] = fx_add(c[k], q);
    cov_s = c;
  endfunction

  function automatic logic correct_pose(longint z[3]);
    mat3_t s, cf, inv, g, c;
    longint y[3];
    longint det, rn, acc;
    int i1, i2, j1, j2;
    rn = reg_sat(rnoise_r);
    s = cov_s;
    for (int k = 0; k < 9; k += 4) s[k] = fx_add(s[k], rn);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        cf[i*3+j] = fx_sub(fx_mul(s[i1*3+j1], s[i2*3+j2]), fx_mul(s[i1*3+j2], s[i2*3+j1]));
      end
    det = fx_add(fx_add(fx_mul(s[0], cf[0]), fx_mul(s[1], cf[1])), fx_mul(s[2], cf[2]));
    if (det == 0) return 1'b1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        inv[i*3+j] = fx_div(cf[j*3+i], det);
    c = cov_s;
    g = mat_mul(c, inv);
    for (int i = 0; i < 3; i++) y[i] = fx_sub(z[i], pose_s[i]);
    for (int i = 0; i < 3; i++) begin
      acc = pose_s[i];
      for (int j = 0; j < 3; j++) acc = fx_add(acc, fx_mul(g[i*3+j], y[j]));
      pose_s[i] = acc;
    end
    for (int k = 0; k < 9; k++) g[k] = fx_sub((k % 4 == 0) ? FX_ONE : 0, g[k]);
    cov_s = mat_mul(g, c);
    return 1'b0;
  endfunction

  // predictor follows every transfer on the command and register channels
  always @(posedge clk) begin
    longint z[3];
    pose_est_t e;
    if (rst) begin
      step_r <= 64'(TS_RESET);
      qnoise_r <= 64'(NOISE_RESET);
      rnoise_r <= 64'(NOISE_RESET);
      cov0_r = 64'(NOISE_RESET);
      for (int k = 0; k < 3; k++) begin
        pose_s[k] = 0;
        ctrl_s[k] = 0;
      end
      for (int k = 0; k < 9; k++) cov_s[k] = (k % 4 == 0) ? longint'(NOISE_RESET) : 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TIME_STEP:  step_r <= 64'(cfg_data[TS_W-1:0]);
          REG_PROC_NOISE: qnoise_r <= 64'(cfg_data);
          REG_MEAS_NOISE: rnoise_r <= 64'(cfg_data);
          REG_INIT_COV: begin
            cov0_r = 64'(cfg_data);
            reload_cov();
          end
        endcase
      end
      if (cmd_valid && !cmd_stall) begin
        case (cmd_t'(command))
          CMD_VEL: begin
            ctrl_s[0] = vel_x;
            ctrl_s[1] = vel_y;
          end
          CMD_YAW: ctrl_s[2] = yaw_rate;
          CMD_PRED: predict_pose();
          CMD_MEAS: begin
            z[0] = meas_x;
            z[1] = meas_y;
            z[2] = meas_heading;
            e.sing = correct_pose(z);
            e.x = fix_t'(pose_s[0]);
            e.y = fix_t'(pose_s[1]);
            e.h = fix_t'(pose_s[2]);
            pose_expected.push_back(e);
          end
        endcase
      end
    end
  end

  // sender: bursts and gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    odo_cmd_t c;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        c = cmd_pending.pop_front();
        cmd_valid <= 1'b1;
        command <= c.command;
        vel_x <= c.vx;
        vel_y <= c.vy;
        yaw_rate <= c.yr;
        meas_x <= c.mx;
        meas_y <= c.my;
        meas_heading <= c.mh;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern plus a long hold-off every so often
  int stall_pct = 0;
  int hold_left = 0;
  int res_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (cycles % 200 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 25;
          3: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end
      if (res_valid && !res_stall) res_count <= res_count + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else if (res_valid && !res_stall && res_count % 40 == 5) begin
        hold_left <= 6000;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    pose_est_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pose_expected.size() == 0) begin
        $error("unexpected result transfer est_x=%0d", est_x);
        errors++;
      end else begin
        e = pose_expected.pop_front();
        if (est_x !== e.x) begin
          $error("est_x: expected %0d, got %0d", e.x, est_x);
          errors++;
        end
        if (est_y !== e.y) begin
          $error("est_y: expected %0d, got %0d", e.y, est_y);
          errors++;
        end
        if (est_heading !== e.h) begin
          $error("est_heading: expected %0d, got %0d", e.h, est_heading);
          errors++;
        end
        if (singular !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_cmd(cmd_t c, fix_t vx, fix_t vy, fix_t yr, fix_t mx, fix_t my, fix_t mh);
    odo_cmd_t t;
    t.command = c;
    t.vx = vx;
    t.vy = vy;
    t.yr = yr;
    t.mx = mx;
    t.my = my;
    t.mh = mh;
    cmd_pending.push_back(t);
  endtask

  function automatic fix_t rand_fix();
    longint v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = SAT_HI;
          1: v = SAT_LO;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2: v = longint'({$urandom, $urandom});
      default: v = longint'($signed($urandom)) <<< $urandom_range(0, 6);
    endcase
    return fix_t'(v);
  endfunction

  task automatic add_random(cmd_t c);
    add_cmd(c, rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix());
  endtask

  task automatic write_reg(reg_idx_t idx, logic [NOISE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain: every command sent, every result back, then let a silent command finish
  task automatic drain();
    @(posedge clk);
    while (cmd_pending.size() > 0 || cmd_valid || pose_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [NOISE_W-1:0] rand_noise();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {NOISE_W{1'b1}};
      2: return NOISE_W'({$urandom, $urandom});
      default: return NOISE_W'($urandom_range(0, 32'h4000_0000));
    endcase
  endfunction

  function automatic logic [NOISE_W-1:0] rand_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return NOISE_W'(64'h1_0000_0000);
      2: return NOISE_W'({$urandom, $urandom});
      default: return NOISE_W'($urandom_range(0, 32'h8000_0000));
    endcase
  endfunction

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (200) @(posedge clk);

    // defaults: extremes of every field and every command
    add_cmd(CMD_MEAS, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_VEL, 48'sd4294967296, -48'sd2147483648, 0, 0, 0, 0);
    add_cmd(CMD_YAW, 0, 0, 48'sd429496730, 0, 0, 0);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_MEAS, 48'sd8589934592, -48'sd4294967296, 48'sd1073741824, 0, 0, 0);
    add_cmd(CMD_VEL, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN);
    add_cmd(CMD_YAW, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_MEAS, 0, 0, 0, VMAX, VMAX, VMAX);
    add_cmd(CMD_MEAS, 0, 0, 0, VMIN, VMIN, VMIN);
    add_cmd(CMD_VEL, -48'sd1, 48'sd1, 0, 0, 0, 0);
    add_cmd(CMD_YAW, 0, 0, VMAX, 0, 0, 0);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_MEAS, 0, 0, 0, -48'sd1, 48'sd1, 0);
    drain();

    // all zero registers: singular innovation, update skipped
    write_reg(REG_TIME_STEP, '0);
    write_reg(REG_PROC_NOISE, '0);
    write_reg(REG_MEAS_NOISE, '0);
    write_reg(REG_INIT_COV, '0);
    add_cmd(CMD_MEAS, 0, 0, 0, 48'sd4294967296, 48'sd4294967296, 0);
    add_cmd(CMD_VEL, 48'sd4294967296, 48'sd4294967296, 0, 0, 0, 0);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_MEAS, 0, 0, 0, VMAX, VMIN, 0);
    drain();

    // noise registers at their widest values, time step at one (2^32)
    write_reg(REG_TIME_STEP, NOISE_W'(64'h1_0000_0000));
    write_reg(REG_PROC_NOISE, {NOISE_W{1'b1}});
    write_reg(REG_MEAS_NOISE, {NOISE_W{1'b1}});
    write_reg(REG_INIT_COV, {NOISE_W{1'b1}});
    add_cmd(CMD_VEL, 48'sd4294967296, -48'sd4294967296, 0, 0, 0, 0);
    add_cmd(CMD_YAW, 0, 0, VMIN, 0, 0, 0);
    add_cmd(CMD_PRED, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_MEAS, 0, 0, 0, 48'sd1, VMAX, VMIN);
    add_cmd(CMD_MEAS, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases: mostly full control-predict-measure sequences
    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 2) != 0) write_reg(REG_TIME_STEP, rand_step());
      if ($urandom_range(0, 2) != 0) write_reg(REG_PROC_NOISE, rand_noise());
      if ($urandom_range(0, 2) != 0) write_reg(REG_MEAS_NOISE, rand_noise());
      if ($urandom_range(0, 2) != 0) write_reg(REG_INIT_COV, rand_noise());
      n = 0;
      while (n < 125) begin
        if ($urandom_range(0, 4) == 0) begin
          add_random(cmd_t'($urandom_range(0, 3)));
          n++;
        end else begin
          add_random(CMD_VEL);
          add_random(CMD_YAW);
          n += 2;
          repeat ($urandom_range(0, 2)) begin
            add_random(CMD_PRED);
            n++;
          end
          add_random(CMD_MEAS);
          n++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pokf_pkg.sv
src/pokf_alu.sv
src/planar_odometry_kalman_filter.sv
test/tb_planar_odometry_kalman_filter.sv
